FILE: sv/markup_tokenizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the markup tokenizer
// Shared concurrent check forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MARKUP_TOKENIZER_UNIT_MACROS_SVH
`define MARKUP_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define MTU_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Implication checked on the following clock edge.
`define MTU_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: sv/mtok_pkg.sv
// ----------------------------------------------------------------------------
// Markup tokenizer package
// Scan states, token types, character codes and character class helpers.
// ----------------------------------------------------------------------------
package mtok_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_KEYWORD   = 10'b00_0000_0010,
    ST_IDENT     = 10'b00_0000_0100,
    ST_NUMBER    = 10'b00_0000_1000,
    ST_STR_START = 10'b00_0001_0000,
    ST_STR_BODY  = 10'b00_0010_0000,
    ST_LINE_CMT  = 10'b00_0100_0000,
    ST_BLK_OPEN  = 10'b00_1000_0000,
    ST_BLK_BODY  = 10'b01_0000_0000,
    ST_BLK_CLOSE = 10'b10_0000_0000
  } scan_state_t;

  typedef enum logic [2:0] {
    TOK_KEYWORD = 3'd0,
    TOK_IDENT   = 3'd1,
    TOK_STRING  = 3'd2,
    TOK_NUMBER  = 3'd3,
    TOK_SYMBOL  = 3'd4,
    TOK_END     = 3'd5
  } token_type_t;

  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_AT         = 8'h40;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_N    = 8'h6E;
  localparam logic [7:0] CH_LOWER_R    = 8'h72;
  localparam logic [7:0] CH_LOWER_T    = 8'h74;

  // One result beat without its position.
  typedef struct packed {
    token_type_t tok_type;
    logic [7:0]  ch;
    logic        ch_valid;
    logic        first;
    logic        last;
  } tok_beat_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alnum(c) || (c == CH_UNDERSCORE) || (c == CH_MINUS);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] d;
    case (c)
      CH_LOWER_N: d = CH_LF;
      CH_LOWER_R: d = CH_CR;
      CH_LOWER_T: d = CH_TAB;
      default:    d = c;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/markup_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Markup tokenizer unit
// Streams source bytes in and token text bytes out, with token type and
// start position on every beat.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          tdata                 tuser       tlast
// s_axis   in   tvalid/tready      char_code[7:0]        mode        end_marker
// m_axis   out  tvalid/tready      text and position     token_type  run_last
//
// One request is taken per cycle while tready is high; its results enter the
// output register (the skid register if that is held) on the same edge
// through the scanner's single level of character-class logic. A request
// gives zero, one or two beats; the end-of-text request gives two when a
// token beat is flushed. tready drops while the skid register is occupied:
// after an output stall, or behind a request that sends two beats.
// Reset is synchronous and returns positions to line 1, column 1.
// ----------------------------------------------------------------------------
module markup_tokenizer_unit #(
  parameter int LINE_BITS   = mtok_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = mtok_pkg::COLUMN_BITS_DEF,
  parameter int TDATA_BITS  = ((11 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] char_code
  input  logic                  s_axis_tuser,  // [0] mode
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] out_char, [8] char_valid, [9] token_first, [10] token_last,
  // then start_line, then start_column, zero fill above
  output logic [TDATA_BITS-1:0] m_axis_tdata,
  output logic [2:0]            m_axis_tuser,  // [2:0] token_type
  output logic                  m_axis_tlast
);
  import mtok_pkg::*;

  logic                   step, push, room;
  logic                   has_main, has_end;
  tok_beat_t              main_beat, out_beat;
  logic [LINE_BITS-1:0]   main_line, end_line, out_line;
  logic [COLUMN_BITS-1:0] main_column, end_column, out_column;

  assign step = s_axis_tvalid && s_axis_tready;

  mtok_scan #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_code   (s_axis_tdata),
    .mode        (s_axis_tuser),
    .end_marker  (s_axis_tlast),
    .push        (push),
    .has_main    (has_main),
    .main_beat   (main_beat),
    .main_line   (main_line),
    .main_column (main_column),
    .has_end     (has_end),
    .end_line    (end_line),
    .end_column  (end_column)
  );

  mtok_outq #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .has_main     (has_main),
    .main_beat    (main_beat),
    .main_line    (main_line),
    .main_column  (main_column),
    .has_end      (has_end),
    .end_line     (end_line),
    .end_column   (end_column),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_beat     (out_beat),
    .out_line     (out_line),
    .out_column   (out_column),
    .out_run_last (m_axis_tlast)
  );

  assign s_axis_tready = room;
  assign m_axis_tdata  = TDATA_BITS'({out_column, out_line, out_beat.last, out_beat.first,
                                      out_beat.ch_valid, out_beat.ch});
  assign m_axis_tuser  = out_beat.tok_type;

endmodule

FILE: sv/mtok_scan.sv
// ----------------------------------------------------------------------------
// Markup tokenizer scanner
// Holds one byte of lookahead and the scan state; classifies the held byte
// against the arriving one and produces the results of one request.
// ----------------------------------------------------------------------------
`include "markup_tokenizer_unit_macros.svh"

module mtok_scan #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              char_code,
  input  logic                    mode,
  input  logic                    end_marker,
  output logic                    push,
  output logic                    has_main,
  output mtok_pkg::tok_beat_t     main_beat,
  output logic [LINE_BITS-1:0]    main_line,
  output logic [COLUMN_BITS-1:0]  main_column,
  output logic                    has_end,
  output logic [LINE_BITS-1:0]    end_line,
  output logic [COLUMN_BITS-1:0]  end_column
);
  import mtok_pkg::*;

  scan_state_t            scan_state, scan_state_next;
  logic [7:0]             held_byte;
  logic                   held_valid;
  logic                   escape_pending, escape_pending_next;
  logic                   number_suffix, number_suffix_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [COLUMN_BITS-1:0] column_count, column_count_next;
  logic [LINE_BITS-1:0]   token_line, token_line_next;
  logic [COLUMN_BITS-1:0] token_column, token_column_next;

  tok_beat_t beat;
  logic      put;

  always_comb begin
    logic [7:0] c;
    logic [7:0] n;
    logic       nv;
    logic       cont;
    logic       esc_arg;
    logic       str_end;
    logic       num_fresh;
    logic       num_cur;

    c   = held_byte;
    nv  = !end_marker;
    n   = nv ? char_code : 8'd0;
    cont    = 1'b0;
    esc_arg = 1'b0;
    str_end = !nv || (n == CH_DQUOTE);
    num_fresh = nv && (is_digit(n) || n == CH_DOT || is_alpha(n) || n == CH_PERCENT);
    num_cur   = number_suffix ? (nv && (is_alnum(n) || n == CH_PERCENT)) : num_fresh;

    scan_state_next     = scan_state;
    escape_pending_next = escape_pending;
    number_suffix_next  = number_suffix;
    line_count_next     = line_count;
    column_count_next   = column_count;
    token_line_next     = token_line;
    token_column_next   = token_column;
    put  = 1'b0;
    beat = '{tok_type: TOK_SYMBOL, ch: c, ch_valid: 1'b1, first: 1'b0, last: 1'b1};

    if (held_valid) begin
      case (scan_state)
        ST_KEYWORD: begin
          cont = nv && is_alpha(n);
          put  = 1'b1;
          beat.tok_type = TOK_KEYWORD;
          beat.last     = !cont;
          if (!cont) scan_state_next = ST_IDLE;
        end
        ST_IDENT: begin
          cont = nv && is_word(n);
          put  = 1'b1;
          beat.tok_type = TOK_IDENT;
          beat.last     = !cont;
          if (!cont) scan_state_next = ST_IDLE;
        end
        ST_NUMBER: begin
          put = 1'b1;
          beat.tok_type = TOK_NUMBER;
          beat.last     = !num_cur;
          number_suffix_next = num_cur && (number_suffix || is_alpha(n) || n == CH_PERCENT);
          if (!num_cur) scan_state_next = ST_IDLE;
        end
        ST_STR_START, ST_STR_BODY: begin
          beat.tok_type = TOK_STRING;
          beat.first    = (scan_state == ST_STR_START);
          beat.last     = str_end;
          if (escape_pending) begin
            esc_arg = 1'b1;
            escape_pending_next = 1'b0;
            put     = 1'b1;
            beat.ch = decode_escape(c);
            scan_state_next = ST_STR_BODY;
          end else if (c == CH_DQUOTE) begin
            scan_state_next = ST_IDLE;
          end else if (c == CH_BACKSLASH && nv) begin
            escape_pending_next = 1'b1;
          end else begin
            put = 1'b1;
            scan_state_next = ST_STR_BODY;
          end
        end
        ST_LINE_CMT: begin
          if (c == CH_LF) scan_state_next = ST_IDLE;
        end
        ST_BLK_OPEN: begin
          scan_state_next = ST_BLK_BODY;
        end
        ST_BLK_BODY: begin
          if (c == CH_STAR && nv && n == CH_SLASH) scan_state_next = ST_BLK_CLOSE;
        end
        ST_BLK_CLOSE: begin
          scan_state_next = ST_IDLE;
        end
        default: begin
          // Between tokens; stray codes behave the same way.
          scan_state_next = ST_IDLE;
          beat.first = 1'b1;
          if (is_space(c)) begin
            scan_state_next = ST_IDLE;
          end else if (c == CH_SLASH && nv && n == CH_SLASH) begin
            scan_state_next = ST_LINE_CMT;
          end else if (c == CH_SLASH && nv && n == CH_STAR) begin
            scan_state_next = ST_BLK_OPEN;
          end else begin
            token_line_next   = line_count;
            token_column_next = column_count;
            put = 1'b1;
            if (c == CH_AT) begin
              cont = nv && is_alpha(n);
              beat.tok_type = TOK_KEYWORD;
              beat.last     = !cont;
              if (cont) scan_state_next = ST_KEYWORD;
            end else if (c == CH_DOT || (c == CH_HASH && mode) || is_alpha(c) ||
                         c == CH_UNDERSCORE) begin
              cont = nv && is_word(n);
              beat.tok_type = TOK_IDENT;
              beat.last     = !cont;
              if (cont) scan_state_next = ST_IDENT;
            end else if (c == CH_DQUOTE) begin
              escape_pending_next = 1'b0;
              beat.tok_type = TOK_STRING;
              if (str_end) begin
                // Empty string: a single result that carries no byte.
                beat.ch       = 8'd0;
                beat.ch_valid = 1'b0;
                scan_state_next = nv ? ST_STR_BODY : ST_IDLE;
              end else begin
                put = 1'b0;
                scan_state_next = ST_STR_START;
              end
            end else if (is_digit(c) || (c == CH_MINUS && nv && is_digit(n))) begin
              beat.tok_type = TOK_NUMBER;
              beat.last     = !num_fresh;
              number_suffix_next = num_fresh && (is_alpha(n) || n == CH_PERCENT);
              if (num_fresh) scan_state_next = ST_NUMBER;
            end else begin
              beat.tok_type = TOK_SYMBOL;
            end
          end
        end
      endcase

      // The byte after a backslash only moves the column, even a newline.
      if (!esc_arg && c == CH_LF) begin
        if (line_count != '1) line_count_next = line_count + 1'b1;
        column_count_next = COLUMN_BITS'(1);
      end else if (column_count != '1) begin
        column_count_next = column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_marker)) begin
      scan_state     <= ST_IDLE;
      held_byte      <= 8'd0;
      held_valid     <= 1'b0;
      escape_pending <= 1'b0;
      number_suffix  <= 1'b0;
      line_count     <= LINE_BITS'(1);
      column_count   <= COLUMN_BITS'(1);
      token_line     <= LINE_BITS'(1);
      token_column   <= COLUMN_BITS'(1);
    end else if (step) begin
      scan_state     <= scan_state_next;
      held_byte      <= char_code;
      held_valid     <= 1'b1;
      escape_pending <= escape_pending_next;
      number_suffix  <= number_suffix_next;
      line_count     <= line_count_next;
      column_count   <= column_count_next;
      token_line     <= token_line_next;
      token_column   <= token_column_next;
    end
  end

  assign has_main    = put;
  assign main_beat   = beat;
  assign main_line   = token_line_next;
  assign main_column = token_column_next;
  assign has_end     = end_marker;
  assign end_line    = line_count_next;
  assign end_column  = column_count_next;
  assign push        = step && (put || end_marker);

  `MTU_ASSERT_NEXT(a_end_clears_scan, step && end_marker,
    !held_valid && scan_state == ST_IDLE, "end of text did not clear the scanner")
  `MTU_ASSERT_NOW(a_escape_in_string, escape_pending,
    scan_state == ST_STR_START || scan_state == ST_STR_BODY,
    "escape pending outside a string")

endmodule

FILE: sv/mtok_outq.sv
// ----------------------------------------------------------------------------
// Markup tokenizer result queue
// Output register plus skid register; each entry holds the results of one
// request, a token beat and/or the end token, sent as one or two beats.
// ----------------------------------------------------------------------------
`include "markup_tokenizer_unit_macros.svh"

module mtok_outq #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    room,
  input  logic                    has_main,
  input  mtok_pkg::tok_beat_t     main_beat,
  input  logic [LINE_BITS-1:0]    main_line,
  input  logic [COLUMN_BITS-1:0]  main_column,
  input  logic                    has_end,
  input  logic [LINE_BITS-1:0]    end_line,
  input  logic [COLUMN_BITS-1:0]  end_column,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mtok_pkg::tok_beat_t     out_beat,
  output logic [LINE_BITS-1:0]    out_line,
  output logic [COLUMN_BITS-1:0]  out_column,
  output logic                    out_run_last
);
  import mtok_pkg::*;

  typedef struct packed {
    logic                   has_main;
    tok_beat_t              main_beat;
    logic [LINE_BITS-1:0]   main_line;
    logic [COLUMN_BITS-1:0] main_column;
    logic                   has_end;
    logic [LINE_BITS-1:0]   end_line;
    logic [COLUMN_BITS-1:0] end_column;
  } entry_t;

  localparam tok_beat_t END_BEAT =
    '{tok_type: TOK_END, ch: 8'd0, ch_valid: 1'b0, first: 1'b1, last: 1'b1};

  entry_t in_entry, head, skid;
  logic   head_valid, skid_valid, phase;
  logic   last_beat, emit_end, pop;

  assign in_entry = '{has_main: has_main, main_beat: main_beat, main_line: main_line,
                      main_column: main_column, has_end: has_end, end_line: end_line,
                      end_column: end_column};

  // The second beat of an entry is always the end token.
  assign last_beat = phase || !(head.has_main && head.has_end);
  assign emit_end  = phase || !head.has_main;
  assign pop       = head_valid && out_ready && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (!head_valid || pop) begin
      phase <= 1'b0;
      if (skid_valid) begin
        head       <= skid;
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
        if (push) head <= in_entry;
      end
    end else begin
      if (out_ready) phase <= 1'b1;
      if (push) begin
        skid       <= in_entry;
        skid_valid <= 1'b1;
      end
    end
  end

  assign room         = !skid_valid;
  assign out_valid    = head_valid;
  assign out_beat     = emit_end ? END_BEAT : head.main_beat;
  assign out_line     = emit_end ? head.end_line : head.main_line;
  assign out_column   = emit_end ? head.end_column : head.main_column;
  assign out_run_last = last_beat;

  `MTU_ASSERT_NOW(a_skid_behind_head, skid_valid, head_valid,
    "skid entry held with an empty output register")
  `MTU_ASSERT_NOW(a_phase_two_beats, phase,
    head_valid && head.has_main && head.has_end,
    "second beat on an entry that has only one")

endmodule
